FILE: rtl/core/cceh_pkg.sv
// ----------------------------------------------------------------------------
// cceh_pkg
// Shared constants, geometry tables and types of the cell energy histogram.
// ----------------------------------------------------------------------------
package cceh_pkg;

    localparam int NUM_BINS   = 1014;
    localparam int SUM_BITS   = 48;
    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int LAYER_BITS = 3;
    localparam int NUM_LAYERS = 6;
    localparam int POS_BITS   = 18;
    localparam int E_BITS     = 32;
    localparam int CELL_BITS  = 7;
    localparam int ARG_BITS   = 18;
    localparam int RCP_BITS   = 24;
    localparam int RCP_SHIFT  = 32;

    localparam logic [BIN_BITS:0]   NUM_BINS_W = (BIN_BITS + 1)'(NUM_BINS);
    localparam logic [BIN_BITS-1:0] OVF_BASE   = BIN_BITS'(1008);
    localparam logic [SUM_BITS-1:0] SUM_MAX    = '1;

    localparam logic      OP_READ     = 1'b1;
    localparam logic [1:0] VK_GAP      = 2'd1;
    localparam logic [1:0] VK_ABSORBER = 2'd2;

    typedef logic signed [POS_BITS-1:0] pos_t;

    // z layer edges in 1/16 mm, strict less-than
    localparam pos_t Z_EDGE [5] = '{
        -18'sd18400, -18'sd12848, -18'sd12160, -18'sd6160, 18'sd4512
    };

    // window half width in 1/16 mm
    localparam logic signed [POS_BITS:0] HALF16 [NUM_LAYERS] = '{
        19'sd3840, 19'sd3840, 19'sd3840, 19'sd16000, 19'sd16000, 19'sd16000
    };
    localparam logic [CELL_BITS-1:0] CELLS_X [NUM_LAYERS] = '{
        7'd3, 7'd12, 7'd12, 7'd3, 7'd12, 7'd12
    };
    localparam logic [CELL_BITS-1:0] CELLS_Y [NUM_LAYERS] = '{
        7'd96, 7'd12, 7'd6, 7'd96, 7'd12, 7'd6
    };
    localparam logic [BIN_BITS-1:0] LAYER_BASE [NUM_LAYERS] = '{
        10'd0, 10'd288, 10'd432, 10'd504, 10'd792, 10'd936
    };
    // ceil(2^32 / (2 * half width in mm))
    localparam logic [RCP_BITS-1:0] RECIP [NUM_LAYERS] = '{
        24'd8947849, 24'd8947849, 24'd8947849,
        24'd2147484, 24'd2147484, 24'd2147484
    };

    typedef struct packed {
        logic [BIN_BITS-1:0] bin;
        logic                add;
        logic                in_range;
        logic [E_BITS-1:0]   energy;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CALC
    } back_state_t;

endpackage

FILE: rtl/core/cceh_front.sv
// ----------------------------------------------------------------------------
// cceh_front
// Three-stage classifier: depth layer, window check and cell scaling,
// reciprocal multiply, then flat bin index pushed into the queue.
// ----------------------------------------------------------------------------
module cceh_front
    import cceh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clearing,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [1:0]          kind,
    input  pos_t                x_pos,
    input  pos_t                y_pos,
    input  pos_t                z_pos,
    input  logic [E_BITS-1:0]   energy,
    input  logic [BIN_BITS-1:0] read_bin,
    output logic                push,
    input  logic                q_full,
    output q_entry_t            push_entry
);

    typedef struct packed {
        logic                  op;
        logic [1:0]            kind;
        logic [E_BITS-1:0]     energy;
        logic [BIN_BITS-1:0]   read_bin;
        logic [LAYER_BITS-1:0] layer;
    } fr_info_t;

    // p strictly inside the window of layer l
    function automatic logic win_inside(pos_t p, logic [LAYER_BITS-1:0] l);
        logic signed [POS_BITS:0] pe;
        pe = (POS_BITS + 1)'(p);
        return (pe > -HALF16[l]) && (pe < HALF16[l]);
    endfunction

    // n * (floor((p + W) / 16) + 1) - 1; cell = this / (2W mm)
    function automatic logic [ARG_BITS-1:0] cell_arg(pos_t p, logic [LAYER_BITS-1:0] l,
                                                     logic [CELL_BITS-1:0] n);
        logic signed [POS_BITS:0] u;
        logic [ARG_BITS-1:0]      t;
        u = (POS_BITS + 1)'(p) + HALF16[l];
        t = ARG_BITS'(u[14:4]) + ARG_BITS'(1);
        return ARG_BITS'(t * ARG_BITS'(n)) - ARG_BITS'(1);
    endfunction

    logic                  advance;
    logic                  accept;
    logic [LAYER_BITS-1:0] layer;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    fr_info_t              s1_info_reg, s2_info_reg, s3_info_reg;
    pos_t                  s1_x_reg, s1_y_reg;
    logic [ARG_BITS-1:0]   s2_ax_reg, s2_ay_reg;
    logic                  s2_inx_reg, s2_iny_reg, s3_inx_reg, s3_iny_reg;
    logic [CELL_BITS-1:0]  s3_cx_reg, s3_cy_reg;
    logic [RCP_BITS+ARG_BITS-1:0] prod_x, prod_y;
    logic [BIN_BITS-1:0]   cell_bin;
    logic [BIN_BITS-1:0]   ovf_bin;

    assign advance  = !s3_valid_reg || !q_full;
    assign in_ready = advance && !clearing;
    assign accept   = in_valid && in_ready;
    assign push     = s3_valid_reg && !q_full;

    always_comb
    begin
        layer = LAYER_BITS'(5);
        for (int k = 4; k >= 0; k--)
        begin
            if (z_pos < Z_EDGE[k])
            begin
                layer = LAYER_BITS'(k);
            end
        end
    end

    assign prod_x = (RCP_BITS + ARG_BITS)'(s2_ax_reg) *
                    (RCP_BITS + ARG_BITS)'(RECIP[s2_info_reg.layer]);
    assign prod_y = (RCP_BITS + ARG_BITS)'(s2_ay_reg) *
                    (RCP_BITS + ARG_BITS)'(RECIP[s2_info_reg.layer]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_info_reg <= '{op: op, kind: kind, energy: energy,
                             read_bin: read_bin, layer: layer};
            s1_x_reg    <= x_pos;
            s1_y_reg    <= y_pos;

            s2_info_reg <= s1_info_reg;
            s2_inx_reg  <= win_inside(s1_x_reg, s1_info_reg.layer);
            s2_iny_reg  <= win_inside(s1_y_reg, s1_info_reg.layer);
            s2_ax_reg   <= cell_arg(s1_x_reg, s1_info_reg.layer, CELLS_X[s1_info_reg.layer]);
            s2_ay_reg   <= cell_arg(s1_y_reg, s1_info_reg.layer, CELLS_Y[s1_info_reg.layer]);

            s3_info_reg <= s2_info_reg;
            s3_inx_reg  <= s2_inx_reg;
            s3_iny_reg  <= s2_iny_reg;
            s3_cx_reg   <= prod_x[RCP_SHIFT +: CELL_BITS];
            s3_cy_reg   <= prod_y[RCP_SHIFT +: CELL_BITS];
        end
    end

    always_comb
    begin
        cell_bin = BIN_BITS'(14'(s3_cx_reg) * 14'(CELLS_Y[s3_info_reg.layer]))
                 + BIN_BITS'(s3_cy_reg) + LAYER_BASE[s3_info_reg.layer];
        ovf_bin  = OVF_BASE + BIN_BITS'(s3_info_reg.layer);
        push_entry.energy = s3_info_reg.energy;
        if (s3_info_reg.op == OP_READ)
        begin
            push_entry.bin      = s3_info_reg.read_bin;
            push_entry.add      = 1'b0;
            push_entry.in_range = {1'b0, s3_info_reg.read_bin} < NUM_BINS_W;
        end
        else
        begin
            // absorber always lands in the layer overflow bin
            if (s3_info_reg.kind == VK_ABSORBER || !s3_inx_reg || !s3_iny_reg)
            begin
                push_entry.bin = ovf_bin;
            end
            else
            begin
                push_entry.bin = cell_bin;
            end
            push_entry.add      = (s3_info_reg.kind == VK_GAP) ||
                                  (s3_info_reg.kind == VK_ABSORBER);
            push_entry.in_range = 1'b1;
        end
    end

endmodule

FILE: rtl/core/cceh_queue.sv
// ----------------------------------------------------------------------------
// cceh_queue
// Two-entry queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module cceh_queue
    import cceh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t head
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/cceh_back.sv
// ----------------------------------------------------------------------------
// cceh_back
// Accumulator memory with read-modify-write, saturation, reset clearing
// sweep and the output register.
// ----------------------------------------------------------------------------
module cceh_back
    import cceh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    output logic                clearing,
    input  logic                q_empty,
    input  q_entry_t            head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BIN_BITS-1:0] out_bin,
    output logic                out_acc,
    output logic                out_sat,
    output logic [47:0]         out_total
);

    back_state_t state_reg, state_next;

    logic [SUM_BITS-1:0] mem [NUM_BINS];
    logic [SUM_BITS-1:0] rd_data_reg;
    logic [BIN_BITS-1:0] clr_cnt_reg;
    q_entry_t            cur_reg;
    logic                out_valid_reg;
    logic                load_out;
    logic                wr_en;
    logic [BIN_BITS-1:0] wr_addr;
    logic [SUM_BITS-1:0] wr_data;
    logic [SUM_BITS:0]   sum_wide;
    logic [SUM_BITS-1:0] new_sum;
    logic [SUM_BITS-1:0] total;
    logic [63:0]         total_wide;

    assign clearing  = state_reg == BK_CLEAR;
    assign out_valid = out_valid_reg;

    assign sum_wide = {1'b0, rd_data_reg} + (SUM_BITS + 1)'(cur_reg.energy);
    assign new_sum  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    always_comb
    begin
        if (!cur_reg.in_range)
        begin
            total = '0;
        end
        else if (cur_reg.add)
        begin
            total = new_sum;
        end
        else
        begin
            total = rd_data_reg;
        end
    end

    assign total_wide = 64'(total);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = cur_reg.bin;
        wr_data    = new_sum;
        unique case (state_reg)
            BK_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if ({1'b0, clr_cnt_reg} == NUM_BINS_W - 1'b1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && (!out_valid_reg || out_ready))
                begin
                    pop        = 1'b1;
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                load_out   = 1'b1;
                wr_en      = cur_reg.add && cur_reg.in_range;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // out-of-range reads are masked by in_range later
        if (pop)
        begin
            rd_data_reg <= mem[head.bin];
            cur_reg     <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_bin   <= cur_reg.bin;
            out_acc   <= cur_reg.add && cur_reg.in_range;
            out_sat   <= total == SUM_MAX;
            out_total <= total_wide[47:0];
        end
    end

endmodule

FILE: rtl/core/calorimeter_cell_energy_histogram.sv
// ----------------------------------------------------------------------------
// calorimeter_cell_energy_histogram
// Bins calorimeter hits into 1014 layer/cell accumulators and reads totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps the accumulator memory to zero, one bin per
// cycle; s_axis_tready stays low during the sweep. The accumulator takes one
// word at a time by read-modify-write on its single memory port: it reads
// the bin as it pops a word, then adds and writes back, and pops no new word
// until the output register is free. The classifier in front is a three-stage
// pipeline feeding a two-entry queue, and a result word is registered after
// these stages, the queue and the accumulator's read. Sums saturate at
// 2^48-1; a read of a bin at or above 1014 returns zero.
module calorimeter_cell_energy_histogram
    import cceh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_pos[17:0], y_pos[35:18], z_pos[53:36], energy[85:54], read_bin[95:86]
    input  logic [95:0] s_axis_tdata,
    // operation[0], volume_kind[2:1]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bin_index[9:0], bin_total[57:10], zero[63:58]
    output logic [63:0] m_axis_tdata,
    // accumulated[0], saturated[1]
    output logic [1:0]  m_axis_tuser
);

    logic                clearing;
    logic                push, q_full, q_empty, pop;
    q_entry_t            push_entry, head;
    logic [BIN_BITS-1:0] out_bin;
    logic                out_acc, out_sat;
    logic [47:0]         out_total;

    cceh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser[0]),
        .kind       (s_axis_tuser[2:1]),
        .x_pos      (s_axis_tdata[17:0]),
        .y_pos      (s_axis_tdata[35:18]),
        .z_pos      (s_axis_tdata[53:36]),
        .energy     (s_axis_tdata[85:54]),
        .read_bin   (s_axis_tdata[95:86]),
        .push       (push),
        .q_full     (q_full),
        .push_entry (push_entry)
    );

    cceh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    cceh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_bin   (out_bin),
        .out_acc   (out_acc),
        .out_sat   (out_sat),
        .out_total (out_total)
    );

    assign m_axis_tdata = {6'd0, out_total, out_bin};
    assign m_axis_tuser = {out_sat, out_acc};

endmodule
